FILE: design/safk_pkg.sv
// ============================================================================
// safk_pkg
// Shared types and constants for the setup-arm forward kinematics unit.
// ============================================================================
package safk_pkg;

	localparam logic signed [31:0] Q_ONE     = 32'sd16777216;
	localparam logic signed [31:0] TWO_PI_Q  = 32'sd105414357;
	localparam logic signed [31:0] PI_Q      = 32'sd52707179;
	localparam logic signed [31:0] HALF_PI_Q = 32'sd26353589;
	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

	localparam logic signed [31:0] K416 = 32'sd6979322;
	localparam logic signed [31:0] K425 = 32'sd7130317;
	localparam logic signed [31:0] K419 = 32'sd7029654;
	localparam logic signed [31:0] K483 = 32'sd8103395;
	localparam logic signed [31:0] K051 = 32'sd855638;
	localparam logic signed [31:0] K189 = 32'sd3170894;
	localparam logic signed [31:0] K016 = 32'sd268435;

	localparam logic OP_LOAD    = 1'b0;
	localparam logic OP_COMPUTE = 1'b1;

	typedef struct packed {
		logic              operation;
		logic [1:0]        row_select;
		logic signed [31:0] frame_x;
		logic signed [31:0] frame_y;
		logic signed [31:0] frame_z;
		logic signed [31:0] frame_t;
		logic signed [31:0] joint_0;
		logic signed [31:0] joint_1;
		logic signed [31:0] joint_2;
		logic signed [31:0] joint_3;
		logic signed [31:0] joint_4;
		logic signed [31:0] joint_5;
	} request_t;

	typedef struct packed {
		logic [1:0]         out_row;
		logic signed [31:0] out_c0;
		logic signed [31:0] out_c1;
		logic signed [31:0] out_c2;
		logic signed [31:0] out_c3;
		logic               last_row;
	} result_t;

	// arctangent table in Q2.30, truncated
	function automatic logic signed [33:0] atan_q30(input int unsigned i);
		logic signed [33:0] t;
		begin
			t = '0;
			case (i)
				0: t = 34'sh03243F6A8;
				1: t = 34'sh01DAC6705;
				2: t = 34'sh00FADBAFC;
				3: t = 34'sh007F56EA6;
				4: t = 34'sh003FEAB76;
				5: t = 34'sh001FFD55B;
				6: t = 34'sh000FFFAAA;
				7: t = 34'sh0007FFF55;
				8: t = 34'sh0003FFFEA;
				9: t = 34'sh0001FFFFD;
				10: t = 34'sh0000FFFFF;
				11: t = 34'sh00007FFFF;
				12: t = 34'sh00003FFFF;
				13: t = 34'sh00001FFFF;
				14: t = 34'sh00000FFFF;
				15: t = 34'sh000007FFF;
				16: t = 34'sh000003FFF;
				17: t = 34'sh000001FFF;
				18: t = 34'sh000000FFF;
				19: t = 34'sh0000007FF;
				20: t = 34'sh0000003FF;
				21: t = 34'sh0000001FF;
				22: t = 34'sh0000000FF;
				23: t = 34'sh00000007F;
				24: t = 34'sh00000003F;
				25: t = 34'sh00000001F;
				26: t = 34'sh00000000F;
				27: t = 34'sh000000008;
				28: t = 34'sh000000004;
				29: t = 34'sh000000002;
				30: t = 34'sh000000001;
				default: t = '0;
			endcase
			return t;
		end
	endfunction

	// clamp to the signed 32-bit range
	function automatic logic signed [31:0] sat32(input logic signed [79:0] v);
		begin
			if (v > 80'sd2147483647) return 32'sh7FFFFFFF;
			if (v < -80'sd2147483648) return 32'sh80000000;
			return v[31:0];
		end
	endfunction

	function automatic logic signed [47:0] mulq(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic signed [63:0] p;
		begin
			p = a * b + 64'sd8388608;
			return 48'(p >>> 24);
		end
	endfunction

	function automatic logic signed [31:0] rq49(input logic signed [79:0] v);
		logic signed [79:0] r;
		begin
			r = (v + 80'sd16777216) >>> 25;
			return sat32(r);
		end
	endfunction

endpackage

FILE: design/safk_cordic.sv
// ============================================================================
// safk_cordic
// Pipelined rotation-mode CORDIC: range reduction, one stage per iteration,
// rounding to Q8.24. One angle enters per cycle while en is high.
// ============================================================================
module safk_cordic #(
	parameter int unsigned ITER = 24
) (
	input  logic               clk,
	input  logic               en,
	input  logic signed [33:0] angle,
	output logic signed [31:0] sin_o,
	output logic signed [31:0] cos_o
);

	// reduction: quotient by reciprocal multiply, then remainder with a
	// single correction step (estimate is off by at most one)
	logic signed [33:0] a_s1;
	logic signed [7:0]  quo_s1;
	logic signed [33:0] r_s2;
	logic signed [33:0] z0;
	logic               n0;
	logic signed [39:0] rr;
	logic signed [33:0] rw;

	// quotient estimate floor(a / 2pi) ~ a * 2^48 / 2pi >> 48
	always_ff @(posedge clk) begin
		if (en) begin
			a_s1   <= angle;
			quo_s1 <= 8'((58'(angle) * 58'sd2670177) >>> 48);
		end
	end

	always_comb begin
		rr = 40'(a_s1) - 40'(quo_s1) * 40'(safk_pkg::TWO_PI_Q);
		if (rr < 0) rr = rr + 40'(safk_pkg::TWO_PI_Q);
		else if (rr >= 40'(safk_pkg::TWO_PI_Q)) rr = rr - 40'(safk_pkg::TWO_PI_Q);
		rw = rr[33:0];
		if (rw >= 34'(safk_pkg::PI_Q)) rw = rw - 34'(safk_pkg::TWO_PI_Q);
	end

	always_ff @(posedge clk) begin
		if (en) r_s2 <= rw;
	end

	// fold into [-pi/2, pi/2]
	always_comb begin
		n0 = 1'b0;
		z0 = r_s2;
		if (r_s2 > 34'(safk_pkg::HALF_PI_Q)) begin
			z0 = r_s2 - 34'(safk_pkg::PI_Q); n0 = 1'b1;
		end else if (r_s2 < -34'(safk_pkg::HALF_PI_Q)) begin
			z0 = r_s2 + 34'(safk_pkg::PI_Q); n0 = 1'b1;
		end
	end

	logic signed [35:0] x_q [ITER+1];
	logic signed [35:0] y_q [ITER+1];
	logic signed [35:0] z_q [ITER+1];
	logic               n_q [ITER+1];

	always_ff @(posedge clk) begin
		if (en) begin
			x_q[0] <= 36'(safk_pkg::CORDIC_GAIN);
			y_q[0] <= '0;
			z_q[0] <= 36'(z0) <<< 6;
			n_q[0] <= n0;
		end
	end

	// one micro-rotation per stage
	for (genvar i = 0; i < ITER; i++) begin : g_it
		logic signed [35:0] dx, dy, at;
		assign dx = x_q[i] >>> i;
		assign dy = y_q[i] >>> i;
		assign at = 36'(safk_pkg::atan_q30(i));
		always_ff @(posedge clk) begin
			if (en) begin
				n_q[i+1] <= n_q[i];
				if (!z_q[i][35]) begin
					x_q[i+1] <= x_q[i] - dy; y_q[i+1] <= y_q[i] + dx;
					z_q[i+1] <= z_q[i] - at;
				end else begin
					x_q[i+1] <= x_q[i] + dy; y_q[i+1] <= y_q[i] - dx;
					z_q[i+1] <= z_q[i] + at;
				end
			end
		end
	end

	logic signed [35:0] xr, yr;
	assign xr = (x_q[ITER] + 36'sd32) >>> 6;
	assign yr = (y_q[ITER] + 36'sd32) >>> 6;

	always_ff @(posedge clk) begin
		if (en) begin
			cos_o <= n_q[ITER] ? -xr[31:0] : xr[31:0];
			sin_o <= n_q[ITER] ? -yr[31:0] : yr[31:0];
		end
	end

endmodule

FILE: design/setup_arm_forward_kinematics_unit.sv
// ============================================================================
// setup_arm_forward_kinematics_unit
// Six-joint setup-arm forward kinematics, Q8.24, pipelined CORDIC trig.
// ============================================================================
// channel  | signals                     | handshake
// request  | start, busy, req            | taken when start && !busy
// result   | res_valid, res              | one row per cycle, cannot stall
// Flow: each compute runs through the CORDIC lanes, pose stage 1, pose stage 2
//   and the row sequencer; its three rows follow on consecutive cycles. busy
//   rises after each compute request and holds off the next one, so rows never
//   overlap on the single result port; computes still overlap in flight.
// Loads write when taken, but busy holds a load off while any compute is in
//   flight, so each compute's rows use the base transform of its own time.
// Reset: base transform returns to identity, pipeline empties.
module setup_arm_forward_kinematics_unit #(
	parameter int unsigned CORDIC_ITERATIONS = 24
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  safk_pkg::request_t  req,
	output logic                res_valid,
	output safk_pkg::result_t   res
);

	localparam int unsigned LAT = CORDIC_ITERATIONS + 3;

	logic       acc;
	logic       inflight;
	logic [1:0] hold_q;
	assign acc  = start && !busy;
	assign busy = (hold_q != 2'd0) || (req.operation == safk_pkg::OP_LOAD && inflight);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) hold_q <= '0;
		else if (acc && req.operation == safk_pkg::OP_COMPUTE) hold_q <= 2'd2;
		else if (hold_q != 2'd0) hold_q <= hold_q - 2'd1;
	end

	// base transform registers
	logic signed [31:0] bt_q [12];
	logic [3:0]         ld_base;
	assign ld_base = {req.row_select, 2'b00};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 12; k++)
				bt_q[k] <= (k == 0 || k == 5 || k == 10) ? safk_pkg::Q_ONE : '0;
		end else if (acc && req.operation == safk_pkg::OP_LOAD && req.row_select != 2'd3) begin
			bt_q[ld_base]        <= req.frame_x;
			bt_q[ld_base + 4'd1] <= req.frame_y;
			bt_q[ld_base + 4'd2] <= req.frame_z;
			bt_q[ld_base + 4'd3] <= req.frame_t;
		end
	end

	// angle sums and difference, and CORDIC lanes
	logic signed [33:0] ang [7];
	logic signed [31:0] sn [7], cs [7];
	assign ang[0] = 34'(req.joint_1);
	assign ang[1] = 34'(req.joint_1) + 34'(req.joint_2);
	assign ang[2] = 34'(req.joint_1) + 34'(req.joint_2) + 34'(req.joint_3);
	assign ang[3] = 34'(req.joint_4) - 34'(req.joint_5);
	assign ang[4] = 34'(req.joint_4) + 34'(req.joint_5);
	assign ang[5] = 34'(req.joint_4);
	assign ang[6] = 34'(req.joint_5);

	for (genvar g = 0; g < 7; g++) begin : g_trig
		safk_cordic #(.ITER(CORDIC_ITERATIONS)) u_cordic (
			.clk(clk), .en(1'b1), .angle(ang[g]),
			.sin_o(sn[g]), .cos_o(cs[g])
		);
	end

	// valid and height travel alongside the CORDIC
	logic               v_d [LAT+1];
	logic signed [31:0] h_d [LAT+1];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= LAT; k++) v_d[k] <= 1'b0;
		end else begin
			v_d[0] <= acc && req.operation == safk_pkg::OP_COMPUTE;
			for (int k = 1; k <= LAT; k++) v_d[k] <= v_d[k-1];
		end
	end
	always_ff @(posedge clk) begin
		h_d[0] <= req.joint_0;
		for (int k = 1; k <= LAT; k++) h_d[k] <= h_d[k-1];
	end

	// pose stage 1: products
	logic signed [31:0] s2, c2, s23, c23, s234, c234, smm, cmm, spp, cpp, s5, c5, s6, c6;
	assign {s2, c2}     = {sn[0], cs[0]};
	assign {s23, c23}   = {sn[1], cs[1]};
	assign {s234, c234} = {sn[2], cs[2]};
	assign {smm, cmm}   = {sn[3], cs[3]};
	assign {spp, cpp}   = {sn[4], cs[4]};
	assign {s5, c5}     = {sn[5], cs[5]};
	assign {s6, c6}     = {sn[6], cs[6]};

	logic signed [32:0] cs56, sd56;
	assign cs56 = 33'(cpp) + 33'(cmm);
	assign sd56 = 33'(spp) - 33'(smm);

	logic signed [79:0] p_s1 [12];
	logic               v_s1, v_s2;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin v_s1 <= 1'b0; v_s2 <= 1'b0; end
		else begin v_s1 <= v_d[LAT]; v_s2 <= v_s1; end
	end

	logic signed [47:0] m_s234s5, m_c234c6, m_c234s5, m_s234c6, m_c6s5, m_s5s6;
	logic signed [47:0] m_s234sd, m_c234sd;
	always_ff @(posedge clk) begin
		m_s234s5 <= safk_pkg::mulq(s234, s5);
		m_c234c6 <= safk_pkg::mulq(c234, c6);
		m_c234s5 <= safk_pkg::mulq(c234, s5);
		m_s234c6 <= safk_pkg::mulq(s234, c6);
		m_c6s5   <= safk_pkg::mulq(c6, s5);
		m_s5s6   <= safk_pkg::mulq(s5, s6);
		m_s234sd <= 48'((80'(s234) * 80'(sd56) + 80'sd8388608) >>> 24);
		m_c234sd <= 48'((80'(c234) * 80'(sd56) + 80'sd8388608) >>> 24);
		p_s1[0]  <= 80'(s234) * 80'(cs56) - 80'sd2 * 80'(c234) * 80'(s6);
		p_s1[1]  <= 80'(s234) * 80'(sd56) + 80'sd2 * 80'(c234) * 80'(c6);
		p_s1[2]  <= -80'(c234) * 80'(cs56) - 80'sd2 * 80'(s234) * 80'(s6);
		p_s1[3]  <= 80'sd2 * 80'(s234) * 80'(c6) - 80'(c234) * 80'(sd56);
		p_s1[4]  <= 80'(safk_pkg::K416) * 80'(c234) + 80'(safk_pkg::K425) * 80'(c23)
			+ 80'(safk_pkg::K419) * 80'(c2);
		p_s1[5]  <= 80'(safk_pkg::K416) * 80'(s234) + 80'(safk_pkg::K425) * 80'(s23)
			+ 80'(safk_pkg::K419) * 80'(s2);
		p_s1[6]  <= 80'(safk_pkg::K051) * 80'(c5);
		p_s1[7]  <= 80'(h_d[LAT]) * 80'(safk_pkg::Q_ONE);
		p_s1[8]  <= 80'(c5);
		p_s1[9]  <= '0;
		p_s1[10] <= '0;
		p_s1[11] <= '0;
	end

	// pose stage 2: assemble, round, saturate
	logic signed [31:0] P_s2 [3][4];
	always_ff @(posedge clk) begin
		P_s2[0][0] <= safk_pkg::sat32(-80'(m_s234s5));
		P_s2[0][1] <= safk_pkg::rq49(p_s1[0]);
		P_s2[0][2] <= safk_pkg::rq49(p_s1[1]);
		P_s2[0][3] <= safk_pkg::rq49(80'sd2 * (p_s1[4]
			+ 80'(safk_pkg::K483) * 80'(m_c234c6) - 80'(safk_pkg::K051) * 80'(m_s234s5)
			+ 80'(safk_pkg::K189) * 80'(safk_pkg::Q_ONE))
			+ 80'(safk_pkg::K483) * 80'(m_s234sd));
		P_s2[1][0] <= safk_pkg::sat32(80'(m_c234s5));
		P_s2[1][1] <= safk_pkg::rq49(p_s1[2]);
		P_s2[1][2] <= safk_pkg::rq49(p_s1[3]);
		P_s2[1][3] <= safk_pkg::rq49(80'sd2 * (p_s1[5]
			+ 80'(safk_pkg::K051) * 80'(m_c234s5) + 80'(safk_pkg::K483) * 80'(m_s234c6))
			- 80'(safk_pkg::K483) * 80'(m_c234sd));
		P_s2[2][0] <= safk_pkg::sat32(p_s1[8] + p_s1[9]);
		P_s2[2][1] <= safk_pkg::sat32(80'(m_c6s5) + p_s1[10]);
		P_s2[2][2] <= safk_pkg::sat32(80'(m_s5s6) + p_s1[11]);
		P_s2[2][3] <= safk_pkg::rq49(80'sd2 * (p_s1[7] + p_s1[6]
			+ 80'(safk_pkg::K483) * 80'(m_s5s6)
			+ 80'(safk_pkg::K016) * 80'(safk_pkg::Q_ONE)));
	end

	// row sequencer: one row of base * pose per cycle
	logic [1:0]         row_q;
	logic               run_q;
	logic signed [31:0] Pk_q [3][4];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0; run_q <= 1'b0;
		end else if (v_s2) begin
			row_q <= 2'd0; run_q <= 1'b1;
		end else if (run_q) begin
			if (row_q == 2'd2) run_q <= 1'b0;
			else row_q <= row_q + 2'd1;
		end
	end
	always_ff @(posedge clk) begin
		if (v_s2) Pk_q <= P_s2;
	end

	// any compute between acceptance and its last row
	always_comb begin
		inflight = v_s1 || v_s2 || run_q;
		for (int k = 0; k <= LAT; k++) inflight = inflight || v_d[k];
	end

	// row products: exact split sum, one rounding
	logic [3:0]         rd_base;
	logic signed [31:0] rowv [4];
	assign rd_base = {row_q, 2'b00};
	always_comb begin
		for (int j = 0; j < 4; j++) begin
			logic signed [63:0] pr, hi;
			logic signed [47:0] hs, ls;
			hs = '0; ls = '0;
			for (int k = 0; k < 3; k++) begin
				pr = 64'(bt_q[rd_base + 4'(k)]) * 64'(Pk_q[k][j]);
				hi = pr >>> 24;
				hs = hs + 48'(hi);
				ls = ls + 48'(pr - (hi <<< 24));
			end
			if (j == 3) hs = hs + 48'(bt_q[rd_base + 4'd3]);
			rowv[j] = safk_pkg::sat32(80'(hs) + 80'((ls + 48'sd8388608) >>> 24));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) res_valid <= 1'b0;
		else res_valid <= run_q;
	end
	always_ff @(posedge clk) begin
		res.out_row  <= row_q;
		res.out_c0   <= rowv[0];
		res.out_c1   <= rowv[1];
		res.out_c2   <= rowv[2];
		res.out_c3   <= rowv[3];
		res.last_row <= (row_q == 2'd2);
	end

	// checks
	a_rows: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.last_row |=> !res_valid || res.out_row == 2'd0)
		else $error("row order broken");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		acc && req.operation == safk_pkg::OP_COMPUTE |=> busy)
		else $error("busy not raised");
	a_run: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> !run_q || row_q == 2'd2)
		else $error("row overlap");

endmodule
